// ===== hw/rtl/chfi_pkg.sv =====
// Shared types and constants of the chained hash find-or-insert table.
`timescale 1ns / 1ps

package chfi_pkg;

    localparam int KEY_W       = 64;
    localparam int ID_W        = 8;
    localparam int HIDX_W      = 32;
    localparam int HTYPE_W     = 3;
    localparam int SLOT_MASK_W = 6;
    localparam int MASK_SPAN   = 2 ** SLOT_MASK_W;

    localparam logic [SLOT_MASK_W-1:0] SLOT_MASK_RST = 6'd63;
    localparam logic [HIDX_W-1:0]      NO_HANDLE     = 32'hFFFF_FFFF;
    localparam logic [HTYPE_W-1:0]     NO_TYPE       = 3'd0;

    // Register word index (byte address bit 2)
    localparam logic REG_SLOT_MASK = 1'b0;

    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_UPDATED  = 2'd3
    } status_t;

    typedef struct packed {
        logic                 req_type;
        logic [KEY_W-1:0]     key;
        logic [ID_W-1:0]      entry_id;
        logic [HIDX_W-1:0]    new_handle_index;
        logic [HTYPE_W-1:0]   new_handle_type;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      result_entry;
        logic [HIDX_W-1:0]    handle_index;
        logic [HTYPE_W-1:0]   handle_type;
    } rsp_t;

endpackage

// ===== hw/rtl/chfi_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module chfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/chained_hash_find_or_insert_core.sv =====
// Top level of the chained hash find-or-insert table: control, sequencer and memories.
`timescale 1ns / 1ps
//
// Key-to-handle table with separate chaining and a free list of entries.
// Request channel (req_valid/req_ready/req): a find item masks the key with
// slot_mask to pick a bucket and walks its chain; on a hit it returns the
// entry and its handle, on a miss it pops a free entry, links it at the
// bucket head and returns it with an invalid handle, or reports full. An
// update item writes a handle into a given entry; an out-of-range entry is
// answered with ST_UPDATED and an invalid handle and is not written.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one result per item.
// A find reads the bucket head, then makes one read of the entry memory per
// chain step, and that memory's single read port sets the pace; a miss then
// reads the free entry and links it. An update reads its entry and writes it
// back. A result passes through a result register into the output register.
// One item is in flight at a time; the next is taken once the result loads.
// The response sits in an output register, so the next item is accepted
// while a result still waits; a stalled receiver then holds that item's
// result back and keeps req_ready low until the output register frees.
// Reset: a clearing pass over max(ENTRIES, SLOTS) addresses (256 by default)
// empties the buckets and rebuilds the free list; req_ready stays low during
// it, while APB writes to slot_mask are taken at any time.

module chained_hash_find_or_insert_core #(
    parameter int ENTRIES = 256,
    parameter int SLOTS   = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  chfi_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output chfi_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    import chfi_pkg::*;

    localparam int EW      = $clog2(ENTRIES);
    localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CLR_LEN = (ENTRIES > SLOTS) ? ENTRIES : SLOTS;
    localparam int CW      = $clog2(CLR_LEN);

    typedef struct packed {
        logic          vld;
        logic [EW-1:0] idx;
    } ptr_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic               lnk_vld;
        logic [EW-1:0]      lnk;
        logic [HIDX_W-1:0]  hidx;
        logic [HTYPE_W-1:0] htype;
    } entry_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HEAD  = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_POP   = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          clr_reg, clr_next;
    logic [SLOT_MASK_W-1:0] slot_mask_reg;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [SW-1:0]          bucket_reg, bucket_next;
    ptr_t                   old_head_reg, old_head_next;
    logic [EW-1:0]          cur_reg, cur_next;
    ptr_t                   free_reg, free_next;
    logic [EW-1:0]          uid_reg, uid_next;
    logic [HIDX_W-1:0]      hidx_reg, hidx_next;
    logic [HTYPE_W-1:0]     htype_reg, htype_next;
    rsp_t                   res_reg, res_next;
    rsp_t                   out_reg, out_next;
    logic                   out_vld_reg, out_vld_next;

    logic                   head_we, head_re;
    logic [SW-1:0]          head_waddr, head_raddr;
    ptr_t                   head_wdata, head_rdata;
    logic                   ent_we, ent_re;
    logic [EW-1:0]          ent_waddr, ent_raddr;
    entry_t                 ent_wdata, ent_rdata;

    logic [SW-1:0]          mod_tbl [MASK_SPAN];
    logic [SLOT_MASK_W-1:0] masked;
    logic [SW-1:0]          bucket_in;
    logic                   id_ok;
    logic                   miss;
    logic                   cfg_wr;
    logic [31:0]            clr_ext;

    // Bucket of each masked key value, folded into the slot count
    for (genvar g = 0; g < MASK_SPAN; g++)
    begin : g_mod
        assign mod_tbl[g] = SW'(g % SLOTS);
    end

    assign masked    = req.key[SLOT_MASK_W-1:0] & slot_mask_reg;
    assign bucket_in = mod_tbl[masked];
    assign id_ok     = 32'(req.entry_id) < 32'(ENTRIES);
    assign clr_ext   = 32'(clr_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SLOT_MASK);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLOT_MASK) ? {26'd0, slot_mask_reg} : 32'd0;

    chfi_ram #(
        .WIDTH ($bits(ptr_t)),
        .DEPTH (SLOTS)
    ) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    chfi_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        key_next      = key_reg;
        bucket_next   = bucket_reg;
        old_head_next = old_head_reg;
        cur_next      = cur_reg;
        free_next     = free_reg;
        uid_next      = uid_reg;
        hidx_next     = hidx_reg;
        htype_next    = htype_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !rsp_ready;
        miss          = 1'b0;

        head_re    = 1'b0;
        head_raddr = bucket_in;
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = '{vld: 1'b1, idx: free_reg.idx};

        ent_re    = 1'b0;
        ent_raddr = free_reg.idx;
        ent_we    = 1'b0;
        ent_waddr = free_reg.idx;
        ent_wdata = '{key: key_reg, lnk_vld: old_head_reg.vld, lnk: old_head_reg.idx,
                      hidx: NO_HANDLE, htype: NO_TYPE};

        unique case (state_reg)
            S_CLEAR:
            begin
                // Empty every bucket and chain entry i to entry i+1
                head_we    = clr_ext < 32'(SLOTS);
                head_waddr = clr_reg[SW-1:0];
                head_wdata = '0;
                ent_we     = clr_ext < 32'(ENTRIES);
                ent_waddr  = clr_reg[EW-1:0];
                ent_wdata  = '{key: '0, lnk_vld: (clr_ext + 32'd1) < 32'(ENTRIES),
                               lnk: EW'(clr_ext + 32'd1), hidx: NO_HANDLE, htype: NO_TYPE};
                if (clr_ext == 32'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = CW'(clr_ext + 32'd1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next    = req.key;
                    bucket_next = bucket_in;
                    uid_next    = EW'(req.entry_id);
                    hidx_next   = req.new_handle_index;
                    htype_next  = req.new_handle_type;
                    if (req.req_type == REQ_FIND)
                    begin
                        head_re    = 1'b1;
                        state_next = S_HEAD;
                    end
                    else if (id_ok)
                    begin
                        ent_re     = 1'b1;
                        ent_raddr  = EW'(req.entry_id);
                        state_next = S_UPD;
                    end
                    else
                    begin
                        res_next   = '{status: ST_UPDATED, result_entry: req.entry_id,
                                       handle_index: NO_HANDLE, handle_type: NO_TYPE};
                        state_next = S_OUT;
                    end
                end
            end
            S_HEAD:
            begin
                old_head_next = head_rdata;
                if (head_rdata.vld)
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = head_rdata.idx;
                    cur_next   = head_rdata.idx;
                    state_next = S_WALK;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            S_WALK:
            begin
                if (ent_rdata.key == key_reg)
                begin
                    res_next   = '{status: ST_FOUND, result_entry: ID_W'(cur_reg),
                                   handle_index: ent_rdata.hidx, handle_type: ent_rdata.htype};
                    state_next = S_OUT;
                end
                else if (ent_rdata.lnk_vld)
                begin
                    ent_re    = 1'b1;
                    ent_raddr = ent_rdata.lnk;
                    cur_next  = ent_rdata.lnk;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            S_POP:
            begin
                // Advance the free list and link the popped entry at the bucket head
                free_next  = '{vld: ent_rdata.lnk_vld, idx: ent_rdata.lnk};
                ent_we     = 1'b1;
                head_we    = 1'b1;
                res_next   = '{status: ST_INSERTED, result_entry: ID_W'(free_reg.idx),
                               handle_index: NO_HANDLE, handle_type: NO_TYPE};
                state_next = S_OUT;
            end
            S_UPD:
            begin
                ent_we     = 1'b1;
                ent_waddr  = uid_reg;
                ent_wdata  = '{key: ent_rdata.key, lnk_vld: ent_rdata.lnk_vld,
                               lnk: ent_rdata.lnk, hidx: hidx_reg, htype: htype_reg};
                res_next   = '{status: ST_UPDATED, result_entry: ID_W'(uid_reg),
                               handle_index: hidx_reg, handle_type: htype_reg};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_vld_reg || rsp_ready)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (miss)
        begin
            if (free_reg.vld)
            begin
                ent_re     = 1'b1;
                ent_raddr  = free_reg.idx;
                state_next = S_POP;
            end
            else
            begin
                res_next   = '{status: ST_FULL, result_entry: '0,
                               handle_index: NO_HANDLE, handle_type: NO_TYPE};
                state_next = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_reg      <= '{vld: 1'b1, idx: '0};
            out_vld_reg   <= 1'b0;
            slot_mask_reg <= SLOT_MASK_RST;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            free_reg    <= free_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr)
            begin
                slot_mask_reg <= pwdata[SLOT_MASK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        bucket_reg   <= bucket_next;
        old_head_reg <= old_head_next;
        cur_reg      <= cur_next;
        uid_reg      <= uid_next;
        hidx_reg     <= hidx_next;
        htype_reg    <= htype_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Bucket heads change only in the clearing pass or together with an insert
    a_head_wr: assert property (@(posedge clk) disable iff (!rst_n)
        head_we |-> (state_reg == S_CLEAR || (state_reg == S_POP && ent_we)))
        else $error("bucket head written outside clear or insert");

    // Entries leave the free list in ascending order and none returns
    a_free_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP && ent_rdata.lnk_vld) |-> (ent_rdata.lnk > free_reg.idx))
        else $error("free list link does not advance");

    a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req_ready)
        else $error("item accepted during clearing pass");

    // A result loads only into a free or draining output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_vld_reg && !rsp_ready) |=> (state_reg == S_OUT))
        else $error("result left while output register was blocked");

endmodule
